### rtl/core/triangle_raster_depth_test_unit_assert.svh
// Assertion macros shared by the rasterizer RTL.
`ifndef TRIANGLE_RASTER_DEPTH_TEST_UNIT_ASSERT_SVH
`define TRIANGLE_RASTER_DEPTH_TEST_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checks a property in every cycle outside reset.
`define TRDT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checks that a condition is followed by a consequence in the next cycle.
`define TRDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define TRDT_ASSERT(lbl, clk, rstn, prop, msg)
`define TRDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/core/trdt_pkg.sv
package trdt_pkg;

    // Screen and depth store geometry.
    localparam int SCREEN_WIDTH  = 600;
    localparam int SCREEN_HEIGHT = 600;
    localparam int STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int Z_W           = 24;

    // Most negative depth, the cleared value of the store.
    localparam logic signed [Z_W-1:0] DEPTH_MIN = {1'b1, {(Z_W-1){1'b0}}};

    // Item codes.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_STEP  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;

endpackage

### rtl/core/trdt_ram.sv
module trdt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/triangle_raster_depth_test_unit.sv
// Triangle rasterizer with a depth store, one pixel per step command.
// Commands: start with i_mode is taken when busy is low. A load stores the
// triangle and its bounding box and answers in the next cycle. A step tests
// the next pixel of the box; each command but MODE_NONE gets one result, flagged
// by o_strobe for a single cycle, and the receiver has no way to hold it off.
// A step answers in the next cycle when the box is used up or the pixel is off
// screen; an uncovered pixel answers after S_CHK, a covered one after S_TEST.
// One 32x24 multiplier is used for all nine products (each through S_MUL and
// S_ACC) and one restoring divider for depth (24 steps) and the three weights
// (17 steps each), loaded in S_DSET and run in S_DIV.
// A clear command rewrites the whole depth store, one entry per cycle, then
// answers. The same pass runs after reset, during which busy is high and no
// command is taken.
// busy is high only during a clear or an on-screen step; a new command may be
// issued in the cycle in which the previous result is shown.
module triangle_raster_depth_test_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [13:0] i_ax,
    input  logic signed [13:0] i_ay,
    input  logic signed [23:0] i_az,
    input  logic signed [13:0] i_bx,
    input  logic signed [13:0] i_by_coord,
    input  logic signed [23:0] i_bz,
    input  logic signed [13:0] i_cx,
    input  logic signed [13:0] i_cy,
    input  logic signed [23:0] i_cz,
    input  logic               i_depth_target,
    output logic               o_strobe,
    output logic               o_written,
    output logic [11:0]        o_pixel_x,
    output logic [11:0]        o_pixel_y,
    output logic signed [23:0] o_depth,
    output logic [16:0]        o_weight_a,
    output logic [16:0]        o_weight_b,
    output logic [16:0]        o_weight_c,
    output logic               o_depth_target_out,
    output logic               o_done_res
);

    `include "triangle_raster_depth_test_unit_assert.svh"

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLEAR = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_DSET  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_TEST  = 4'd8;

    logic [3:0] r_state;

    // Triangle and scan state.
    logic signed [13:0] r_x0, r_y0, r_xmin, r_xmax, r_ymax, r_scan_x, r_scan_y;
    logic signed [14:0] r_e1x, r_e2x, r_e1y, r_e2y, r_dx, r_dy;
    logic signed [23:0] r_az, r_bz, r_cz;
    logic               r_flag;

    // Per pixel working registers.
    logic [11:0]         r_px, r_py;
    trdt_pkg::t_addr     r_addr, r_clr_addr;
    logic [3:0]          r_k;
    logic signed [55:0]  r_prod, r_acc;
    logic signed [31:0]  r_nb, r_nc, r_d, r_na;
    logic [55:0]         r_rem, r_dsr;
    logic [23:0]         r_quo;
    logic [4:0]          r_cnt;
    logic [1:0]          r_dsel;
    logic                r_neg;
    logic signed [23:0]  r_z;
    logic [16:0]         r_wa, r_wb, r_wc;

    // Result registers.
    logic               r_o_strobe, r_o_written, r_o_flag, r_o_done;
    logic [11:0]        r_o_px, r_o_py;
    logic signed [23:0] r_o_depth;
    logic [16:0]        r_o_wa, r_o_wb, r_o_wc;

    logic accept;
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Box of the incoming triangle.
    logic signed [13:0] w_xmin, w_xmax, w_ymin, w_ymax;
    always_comb begin
        w_xmin = (i_ax < i_bx) ? i_ax : i_bx;
        w_xmin = (w_xmin < i_cx) ? w_xmin : i_cx;
        w_xmax = (i_ax > i_bx) ? i_ax : i_bx;
        w_xmax = (w_xmax > i_cx) ? w_xmax : i_cx;
        w_ymin = (i_ay < i_by_coord) ? i_ay : i_by_coord;
        w_ymin = (w_ymin < i_cy) ? w_ymin : i_cy;
        w_ymax = (i_ay > i_by_coord) ? i_ay : i_by_coord;
        w_ymax = (w_ymax > i_cy) ? w_ymax : i_cy;
    end

    // Next scan position and screen check of the current one.
    logic signed [13:0] w_nx;
    logic               w_wrap, w_onscreen;
    assign w_nx   = r_scan_x + 14'sd1;
    assign w_wrap = (w_nx >= r_xmax);
    assign w_onscreen = !r_scan_x[13] && !r_scan_y[13]
                     && (r_scan_x < 14'(trdt_pkg::SCREEN_WIDTH))
                     && (r_scan_y < 14'(trdt_pkg::SCREEN_HEIGHT));

    // Last entry of the clearing sweep.
    logic w_clr_last;
    assign w_clr_last = (r_clr_addr == trdt_pkg::ADDR_W'(trdt_pkg::STORE_DEPTH - 1));

    // Shared multiplier operand selection.
    logic signed [31:0] w_ma;
    logic signed [23:0] w_mb;
    logic signed [55:0] w_prod;
    always_comb begin
        unique case (r_k)
            4'd0:    begin w_ma = 32'(r_e2x); w_mb = 24'(r_dy);  end
            4'd1:    begin w_ma = 32'(r_dx);  w_mb = 24'(r_e2y); end
            4'd2:    begin w_ma = 32'(r_dx);  w_mb = 24'(r_e1y); end
            4'd3:    begin w_ma = 32'(r_e1x); w_mb = 24'(r_dy);  end
            4'd4:    begin w_ma = 32'(r_e1x); w_mb = 24'(r_e2y); end
            4'd5:    begin w_ma = 32'(r_e2x); w_mb = 24'(r_e1y); end
            4'd6:    begin w_ma = r_na;       w_mb = r_az;       end
            4'd7:    begin w_ma = r_nb;       w_mb = r_bz;       end
            4'd8:    begin w_ma = r_nc;       w_mb = r_cz;       end
            default: begin w_ma = '0;         w_mb = '0;         end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // Accumulation: first product of a pair loads, second subtracts, depth sums.
    logic signed [55:0] w_acc;
    always_comb begin
        priority if (r_k == 4'd0 || r_k == 4'd2 || r_k == 4'd4 || r_k == 4'd6) begin
            w_acc = r_prod;
        end else if (r_k == 4'd7 || r_k == 4'd8) begin
            w_acc = r_acc + r_prod;
        end else begin
            w_acc = r_acc - r_prod;
        end
    end

    // Sign normalization and the first coverage term.
    logic signed [31:0] w_dn, w_nbn, w_ncn, w_na;
    assign w_dn  = r_d[31] ? -r_d  : r_d;
    assign w_nbn = r_d[31] ? -r_nb : r_nb;
    assign w_ncn = r_d[31] ? -r_nc : r_nc;
    assign w_na  = w_dn - w_nbn - w_ncn;

    // A degenerate triangle or a negative term leaves the pixel uncovered.
    logic w_uncov;
    assign w_uncov = (r_d == 32'sd0) || (w_na < 0) || (w_nbn < 0) || (w_ncn < 0);

    // A result is shown in the cycle after one of these events.
    logic n_o_strobe;
    assign n_o_strobe = ((r_state == S_CLEAR) && w_clr_last)
                     || (accept && (i_mode == trdt_pkg::MODE_LOAD))
                     || (accept && (i_mode == trdt_pkg::MODE_STEP)
                         && ((r_scan_y >= r_ymax) || !w_onscreen))
                     || ((r_state == S_CHK) && w_uncov)
                     || (r_state == S_TEST);

    // One restoring divider step.
    logic        w_ge;
    logic [23:0] w_quo;
    assign w_ge  = (r_rem >= r_dsr);
    assign w_quo = {r_quo[22:0], w_ge};

    // Depth store.
    logic [23:0]     w_rdata;
    logic            w_pass, w_we;
    trdt_pkg::t_addr w_waddr;
    logic [23:0]     w_wdata;
    assign w_pass  = (r_z > $signed(w_rdata));
    assign w_we    = (r_state == S_INIT) || (r_state == S_CLEAR)
                  || ((r_state == S_TEST) && w_pass);
    assign w_waddr = (r_state == S_TEST) ? r_addr : r_clr_addr;
    assign w_wdata = (r_state == S_TEST) ? r_z : trdt_pkg::DEPTH_MIN;

    trdt_ram #(
        .WIDTH (trdt_pkg::Z_W),
        .DEPTH (trdt_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
            r_state    <= S_INIT;
            r_clr_addr <= '0;
            r_x0 <= '0; r_y0 <= '0;
            r_e1x <= '0; r_e2x <= '0; r_e1y <= '0; r_e2y <= '0;
            r_az <= '0; r_bz <= '0; r_cz <= '0;
            r_xmin <= '0; r_xmax <= '0; r_ymax <= '0;
            r_scan_x <= '0; r_scan_y <= '0;
            r_flag <= 1'b0;
            r_addr <= '0;
            r_k    <= '0;
        end else begin
            r_o_strobe <= n_o_strobe;
            unique case (r_state)
                S_INIT, S_CLEAR: begin
                    // Sweep the store with the cleared depth.
                    if (w_clr_last) begin
                        r_clr_addr <= '0;
                        if (r_state == S_CLEAR) begin
                            r_o_written <= 1'b0;
                            r_o_px <= '0; r_o_py <= '0; r_o_depth <= '0;
                            r_o_wa <= '0; r_o_wb <= '0; r_o_wc <= '0;
                            r_o_flag <= r_flag; r_o_done <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + trdt_pkg::ADDR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_o_written <= 1'b0;
                        r_o_px <= '0; r_o_py <= '0; r_o_depth <= '0;
                        r_o_wa <= '0; r_o_wb <= '0; r_o_wc <= '0;
                        unique case (i_mode)
                            trdt_pkg::MODE_LOAD: begin
                                r_x0 <= i_ax; r_y0 <= i_ay;
                                r_e1x <= 15'(i_bx) - 15'(i_ax);
                                r_e2x <= 15'(i_cx) - 15'(i_ax);
                                r_e1y <= 15'(i_by_coord) - 15'(i_ay);
                                r_e2y <= 15'(i_cy) - 15'(i_ay);
                                r_az <= i_az; r_bz <= i_bz; r_cz <= i_cz;
                                r_flag <= i_depth_target;
                                r_xmin <= w_xmin; r_xmax <= w_xmax;
                                r_ymax <= w_ymax;
                                r_scan_x <= w_xmin;
                                r_scan_y <= (w_xmin < w_xmax) ? w_ymin : w_ymax;
                                r_o_flag <= i_depth_target; r_o_done <= 1'b1;
                            end
                            trdt_pkg::MODE_CLEAR: begin
                                r_state <= S_CLEAR;
                            end
                            trdt_pkg::MODE_STEP: begin
                                r_o_flag <= r_flag;
                                if (r_scan_y >= r_ymax) begin
                                    r_o_done <= 1'b1;
                                end else begin
                                    // Advance the scan, columns inner.
                                    if (w_wrap) begin
                                        r_scan_x <= r_xmin;
                                        r_scan_y <= r_scan_y + 14'sd1;
                                    end else begin
                                        r_scan_x <= w_nx;
                                    end
                                    r_o_done <= 1'b0;
                                    if (w_onscreen) begin
                                        r_px <= r_scan_x[11:0];
                                        r_py <= r_scan_y[11:0];
                                        r_addr <= trdt_pkg::ADDR_W'(
                                            32'(r_scan_y[11:0]) * trdt_pkg::SCREEN_WIDTH
                                            + 32'(r_scan_x[11:0]));
                                        r_dx <= 15'(r_x0) - 15'(r_scan_x);
                                        r_dy <= 15'(r_y0) - 15'(r_scan_y);
                                        r_k <= '0;
                                        r_state <= S_MUL;
                                    end
                                end
                            end
                            trdt_pkg::MODE_NONE: begin
                                r_state <= S_IDLE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= w_acc;
                    if (r_k == 4'd1) r_nb <= 32'(w_acc);
                    if (r_k == 4'd3) r_nc <= 32'(w_acc);
                    if (r_k == 4'd5) r_d  <= 32'(w_acc);
                    if (r_k == 4'd5) begin
                        r_state <= S_CHK;
                    end else if (r_k == 4'd8) begin
                        r_dsel  <= 2'd0;
                        r_state <= S_DSET;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_CHK: begin
                    // Degenerate or outside: report the pixel uncovered.
                    if (w_uncov) begin
                        r_o_px <= r_px; r_o_py <= r_py;
                        r_state <= S_IDLE;
                    end else begin
                        r_d <= w_dn; r_nb <= w_nbn; r_nc <= w_ncn; r_na <= w_na;
                        r_k <= 4'd6;
                        r_state <= S_MUL;
                    end
                end
                S_DSET: begin
                    // Load the divider: depth first, then the three weights.
                    r_quo <= '0;
                    unique case (r_dsel)
                        2'd0: begin
                            r_neg <= r_acc[55];
                            r_rem <= r_acc[55] ? 56'(-r_acc) : 56'(r_acc);
                            r_dsr <= 56'(r_d) << 23;
                            r_cnt <= 5'd23;
                        end
                        2'd1: begin
                            r_rem <= 56'(r_na) << 16;
                            r_dsr <= 56'(r_d) << 16;
                            r_cnt <= 5'd16;
                        end
                        2'd2: begin
                            r_rem <= 56'(r_nb) << 16;
                            r_dsr <= 56'(r_d) << 16;
                            r_cnt <= 5'd16;
                        end
                        default: begin
                            r_rem <= 56'(r_nc) << 16;
                            r_dsr <= 56'(r_d) << 16;
                            r_cnt <= 5'd16;
                        end
                    endcase
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_ge) r_rem <= r_rem - r_dsr;
                    r_dsr <= r_dsr >> 1;
                    r_quo <= w_quo;
                    if (r_cnt == 5'd0) begin
                        unique case (r_dsel)
                            2'd0:    r_z  <= r_neg ? -w_quo : w_quo;
                            2'd1:    r_wa <= w_quo[16:0];
                            2'd2:    r_wb <= w_quo[16:0];
                            default: r_wc <= w_quo[16:0];
                        endcase
                        if (r_dsel == 2'd3) begin
                            r_state <= S_TEST;
                        end else begin
                            r_dsel  <= r_dsel + 2'd1;
                            r_state <= S_DSET;
                        end
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_TEST: begin
                    // Depth test against the stored value, write on pass.
                    r_o_written <= w_pass;
                    r_o_px <= r_px; r_o_py <= r_py; r_o_depth <= r_z;
                    r_o_wa <= r_wa; r_o_wb <= r_wb; r_o_wc <= r_wc;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe           = r_o_strobe;
    assign o_written          = r_o_written;
    assign o_pixel_x          = r_o_px;
    assign o_pixel_y          = r_o_py;
    assign o_depth            = r_o_depth;
    assign o_weight_a         = r_o_wa;
    assign o_weight_b         = r_o_wb;
    assign o_weight_c         = r_o_wc;
    assign o_depth_target_out = r_o_flag;
    assign o_done_res         = r_o_done;

    `TRDT_ASSERT(a_strobe_idle, i_clk, i_rst_n, !r_o_strobe || r_state == S_IDLE, "busy result")
    `TRDT_ASSERT(a_written_step, i_clk, i_rst_n, !(r_o_strobe && r_o_written) || !r_o_done, "done write")
    `TRDT_ASSERT(a_weight_range, i_clk, i_rst_n, !(r_o_strobe && r_o_written) || (r_o_wa <= 17'd65536 && r_o_wb <= 17'd65536), "weight range")
    `TRDT_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, r_state == S_DSET, r_state == S_DIV, "divider idle")

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    // One command and one pixel result as seen on the ports.
    typedef struct {
        logic [1:0]         mode;
        logic signed [13:0] ax, ay, bx, by, cx, cy;
        logic signed [23:0] az, bz, cz;
        logic               dt;
    } t_cmd;

    typedef struct {
        logic               written;
        logic [11:0]        px, py;
        logic signed [23:0] depth;
        logic [16:0]        wa, wb, wc;
        logic               dto;
        logic               done;
    } t_pix;

    // Stimulus table row: a command, a repeat count, and an optional literal result.
    typedef struct {
        t_cmd c;
        int   reps;
        bit   lit;
        t_pix r;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_mode = trdt_pkg::MODE_NONE;
    logic signed [13:0] i_ax = '0, i_ay = '0, i_bx = '0, i_by_coord = '0, i_cx = '0, i_cy = '0;
    logic signed [23:0] i_az = '0, i_bz = '0, i_cz = '0;
    logic               i_depth_target = 1'b0;
    logic               o_strobe, o_written, o_depth_target_out, o_done_res;
    logic [11:0]        o_pixel_x, o_pixel_y;
    logic signed [23:0] o_depth;
    logic [16:0]        o_weight_a, o_weight_b, o_weight_c;

    triangle_raster_depth_test_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_ax(i_ax), .i_ay(i_ay), .i_az(i_az),
        .i_bx(i_bx), .i_by_coord(i_by_coord), .i_bz(i_bz),
        .i_cx(i_cx), .i_cy(i_cy), .i_cz(i_cz), .i_depth_target(i_depth_target),
        .o_strobe(o_strobe), .o_written(o_written), .o_pixel_x(o_pixel_x),
        .o_pixel_y(o_pixel_y), .o_depth(o_depth), .o_weight_a(o_weight_a),
        .o_weight_b(o_weight_b), .o_weight_c(o_weight_c),
        .o_depth_target_out(o_depth_target_out), .o_done_res(o_done_res)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the rasterizer state.
    longint             tri_x[3], tri_y[3], tri_z[3];
    longint             scan_col, scan_row, col_lo, col_hi, row_lo, row_hi;
    logic               draw_flag;
    logic signed [23:0] zbuf [0:trdt_pkg::STORE_DEPTH-1];

    t_pix pending_pixels[$];
    int   mismatches = 0;
    int   n_items = 0, n_results = 0, n_written = 0, n_covered = 0;
    int   burst_left = 0;

    // Computes the result of one command and advances the shadow state.
    task automatic raster_predict(input t_cmd c, output bit has_res, output t_pix r);
        longint px, py, e1x, e2x, e1y, e2y, dx, dy, nb, nc, d, na, z;
        int     idx;
        r = '{default: '0};
        has_res = 1'b1;
        case (c.mode)
            trdt_pkg::MODE_LOAD: begin
                tri_x[0] = c.ax; tri_y[0] = c.ay; tri_z[0] = c.az;
                tri_x[1] = c.bx; tri_y[1] = c.by; tri_z[1] = c.bz;
                tri_x[2] = c.cx; tri_y[2] = c.cy; tri_z[2] = c.cz;
                draw_flag = c.dt;
                col_lo = tri_x[0]; col_hi = tri_x[0]; row_lo = tri_y[0]; row_hi = tri_y[0];
                for (int i = 1; i < 3; i++) begin
                    if (tri_x[i] < col_lo) col_lo = tri_x[i];
                    if (tri_x[i] > col_hi) col_hi = tri_x[i];
                    if (tri_y[i] < row_lo) row_lo = tri_y[i];
                    if (tri_y[i] > row_hi) row_hi = tri_y[i];
                end
                scan_col = col_lo;
                scan_row = (col_lo < col_hi) ? row_lo : row_hi;
                r.dto = draw_flag;
                r.done = 1'b1;
            end
            trdt_pkg::MODE_CLEAR: begin
                for (int i = 0; i < trdt_pkg::STORE_DEPTH; i++) zbuf[i] = trdt_pkg::DEPTH_MIN;
                r.dto = draw_flag;
                r.done = 1'b1;
            end
            trdt_pkg::MODE_NONE: has_res = 1'b0;
            default: begin
                r.dto = draw_flag;
                if (scan_row >= row_hi) begin
                    r.done = 1'b1;
                end else begin
                    px = scan_col; py = scan_row;
                    scan_col = px + 1;
                    if (scan_col >= col_hi) begin
                        scan_col = col_lo;
                        scan_row = py + 1;
                    end
                    if (px >= 0 && px < trdt_pkg::SCREEN_WIDTH &&
                        py >= 0 && py < trdt_pkg::SCREEN_HEIGHT) begin
                        r.px = px[11:0];
                        r.py = py[11:0];
                        e1x = tri_x[1] - tri_x[0]; e2x = tri_x[2] - tri_x[0];
                        e1y = tri_y[1] - tri_y[0]; e2y = tri_y[2] - tri_y[0];
                        dx = tri_x[0] - px; dy = tri_y[0] - py;
                        nb = e2x * dy - dx * e2y;
                        nc = dx * e1y - e1x * dy;
                        d = e1x * e2y - e2x * e1y;
                        if (d < 0) begin
                            d = -d; nb = -nb; nc = -nc;
                        end
                        na = d - nb - nc;
                        if (d != 0 && na >= 0 && nb >= 0 && nc >= 0) begin
                            z = (na * tri_z[0] + nb * tri_z[1] + nc * tri_z[2]) / d;
                            r.depth = z[23:0];
                            r.wa = 17'((na * 65536) / d);
                            r.wb = 17'((nb * 65536) / d);
                            r.wc = 17'((nc * 65536) / d);
                            idx = int'(py) * trdt_pkg::SCREEN_WIDTH + int'(px);
                            if (z > longint'(zbuf[idx])) begin
                                zbuf[idx] = z[23:0];
                                r.written = 1'b1;
                            end
                        end
                    end
                end
            end
        endcase
    endtask

    // Issues one command at a falling edge and waits for its transfer.
    task automatic issue(input t_cmd c, input bit lit, input t_pix lr);
        bit   has_res;
        t_pix r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                start = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_mode = c.mode;
        i_ax = c.ax; i_ay = c.ay; i_az = c.az;
        i_bx = c.bx; i_by_coord = c.by; i_bz = c.bz;
        i_cx = c.cx; i_cy = c.cy; i_cz = c.cz;
        i_depth_target = c.dt;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        raster_predict(c, has_res, r);
        if (has_res) pending_pixels.push_back(lit ? lr : r);
        if (c.mode != trdt_pkg::MODE_NONE) n_items++;
        @(negedge i_clk);
    endtask

    // Compares every result transfer with the oldest expected pixel.
    always @(posedge i_clk) begin
        t_pix e;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (o_written) n_written++;
            if (o_weight_a != 0 || o_weight_b != 0 || o_weight_c != 0) n_covered++;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                e = pending_pixels.pop_front();
                if (o_written !== e.written || o_pixel_x !== e.px || o_pixel_y !== e.py ||
                    o_depth !== e.depth || o_weight_a !== e.wa || o_weight_b !== e.wb ||
                    o_weight_c !== e.wc || o_depth_target_out !== e.dto ||
                    o_done_res !== e.done) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: exp w%0b x%0d y%0d z%0d %0d/%0d/%0d t%0b d%0b",
                            $realtime, e.written, e.px, e.py, e.depth, e.wa, e.wb, e.wc,
                            e.dto, e.done);
                        $display("    got w%0b x%0d y%0d z%0d %0d/%0d/%0d t%0b d%0b",
                            o_written, o_pixel_x, o_pixel_y, o_depth,
                            o_weight_a, o_weight_b, o_weight_c, o_depth_target_out,
                            o_done_res);
                    end
                end
            end
        end
    end

    function automatic t_cmd mk(logic [1:0] m, int ax, int ay, int az, int bx, int by,
                                int bz, int cx, int cy, int cz, bit dt);
        t_cmd c;
        c.mode = m;
        c.ax = ax[13:0]; c.ay = ay[13:0]; c.az = az[23:0];
        c.bx = bx[13:0]; c.by = by[13:0]; c.bz = bz[23:0];
        c.cx = cx[13:0]; c.cy = cy[13:0]; c.cz = cz[23:0];
        c.dt = dt;
        return c;
    endfunction

    function automatic t_pix ack(bit dt, bit done);
        t_pix r = '{default: '0};
        r.dto = dt;
        r.done = done;
        return r;
    endfunction

    initial begin
        t_row   rows[$];
        t_cmd   c, stepc;
        t_pix   none;
        int     base_x, base_y, sz, kind, steps, area;
        longint x0, x1, y0, y1;

        none = '{default: '0};
        stepc = mk(trdt_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < trdt_pkg::STORE_DEPTH; i++) zbuf[i] = trdt_pkg::DEPTH_MIN;
        for (int i = 0; i < 3; i++) begin
            tri_x[i] = 0; tri_y[i] = 0; tri_z[i] = 0;
        end
        scan_col = 0; scan_row = 0; col_lo = 0; col_hi = 0; row_lo = 0; row_hi = 0;
        draw_flag = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: after reset, extremes, coverage, depth test, clear, special cases.
        rows.push_back('{stepc, 1, 1, ack(0, 1)});
        rows.push_back('{mk(trdt_pkg::MODE_LOAD, -8192, -8192, -8388608, 8191, 8191, 8388607,
                            0, 8191, 0, 1), 1, 1, ack(1, 1)});
        rows.push_back('{stepc, 2, 1, ack(1, 0)});
        rows.push_back('{mk(trdt_pkg::MODE_LOAD, 0, 0, 100, 2, 0, 200, 0, 2, 300, 0),
                         1, 1, ack(0, 1)});
        rows.push_back('{stepc, 5, 0, none});
        // Same triangle farther away: covered pixels fail the depth test.
        rows.push_back('{mk(trdt_pkg::MODE_LOAD, 0, 0, 10, 2, 0, 20, 0, 2, 30, 0),
                         1, 0, none});
        rows.push_back('{stepc, 5, 0, none});
        rows.push_back('{mk(trdt_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1),
                         1, 1, ack(0, 1)});
        // Collinear vertices cover nothing.
        rows.push_back('{mk(trdt_pkg::MODE_LOAD, 0, 0, 5, 2, 2, 5, 4, 4, 5, 1), 1, 0, none});
        rows.push_back('{stepc, 3, 0, none});
        // Zero-width box reports done at once.
        rows.push_back('{mk(trdt_pkg::MODE_LOAD, 5, 5, 1, 5, 9, 2, 5, 1, 3, 1),
                         1, 1, ack(1, 1)});
        rows.push_back('{stepc, 1, 1, ack(1, 1)});
        rows.push_back('{mk(trdt_pkg::MODE_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none});
        rows.push_back('{mk(trdt_pkg::MODE_LOAD, 599, 597, 8388607, 597, 599, -8388608,
                            599, 599, 8388607, 0), 1, 0, none});
        rows.push_back('{stepc, 5, 0, none});
        foreach (rows[i])
            for (int k = 0; k < rows[i].reps; k++) issue(rows[i].c, rows[i].lit, rows[i].r);

        // Random triangles, mostly small and overlapping so the depth test bites.
        while (n_items < 1800) begin
            kind = $urandom_range(0, 19);
            c.mode = trdt_pkg::MODE_LOAD;
            c.dt = 1'($urandom_range(0, 1));
            c.az = 24'($urandom); c.bz = 24'($urandom); c.cz = 24'($urandom);
            if (kind < 2) begin
                c.ax = 14'($urandom); c.ay = 14'($urandom); c.bx = 14'($urandom);
                c.by = 14'($urandom); c.cx = 14'($urandom); c.cy = 14'($urandom);
            end else begin
                if (kind < 4) begin
                    base_x = $urandom_range(0, 1) ? -5 : 593;
                    base_y = $urandom_range(0, 1) ? -5 : 593;
                end else begin
                    base_x = $urandom_range(0, 40);
                    base_y = $urandom_range(0, 40);
                end
                sz = $urandom_range(1, 8);
                c.ax = 14'(base_x + $urandom_range(0, sz));
                c.ay = 14'(base_y + $urandom_range(0, sz));
                c.bx = 14'(base_x + $urandom_range(0, sz));
                c.by = 14'(base_y + $urandom_range(0, sz));
                c.cx = 14'(base_x + $urandom_range(0, sz));
                c.cy = 14'(base_y + $urandom_range(0, sz));
                if (kind == 4) begin
                    c.cx = 14'(2 * c.bx - c.ax);
                    c.cy = 14'(2 * c.by - c.ay);
                end
            end
            issue(c, 0, none);
            x0 = col_lo; x1 = col_hi; y0 = row_lo; y1 = row_hi;
            area = (kind < 2) ? 0 : int'((x1 - x0) * (y1 - y0));
            steps = (kind < 2) ? $urandom_range(1, 4) : area + $urandom_range(1, 3);
            for (int k = 0; k < steps; k++) begin
                if ($urandom_range(0, 49) == 0)
                    issue(mk(trdt_pkg::MODE_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
                issue(stepc, 0, none);
            end
        end

        start = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Ran %0d commands: %0d results, %0d covered pixels, %0d depth writes.",
                 n_items, n_results, n_covered, n_written);
        $display("Mismatches: %0d.", mismatches);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog: covers both clearing passes and slow covered pixels many times over.
    initial begin
        #100_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/trdt_pkg.sv
rtl/core/trdt_ram.sv
rtl/core/triangle_raster_depth_test_unit.sv
test/tb.sv
